FILE: rtl/sss_pkg.sv
// Shared types, constants and small arithmetic helpers for the SSS generator.
// No dependencies; used by every module under rtl/.
package sss_pkg;

  // Length of each m-sequence
  localparam int unsigned SeqLen = 31;

  // m-sequences x_s, x_c, x_z from start state 0 0 0 0 1; bit i is element i
  localparam logic [SeqLen-1:0] SeqS = 31'b1010111011000111110011010010000;
  localparam logic [SeqLen-1:0] SeqC = 31'b1001011001111100011011101010000;
  localparam logic [SeqLen-1:0] SeqZ = 31'b1101010010001011111011001110000;

  // cell_id / 3 as (cell_id * 683) >> 11, exact for 9-bit inputs
  localparam logic [9:0] Div3Mul   = 10'd683;
  localparam int unsigned Div3Shift = 11;

  // Positions of interest in the emitted sequence
  localparam logic [5:0] PosDc      = 6'd31;
  localparam logic [5:0] PosLastNoDc = 6'd61;
  localparam logic [5:0] PosLastDc   = 6'd62;

  // Chip codes
  localparam logic signed [1:0] ChipPos  = 2'sb01;
  localparam logic signed [1:0] ChipNeg  = 2'sb11;
  localparam logic signed [1:0] ChipZero = 2'sb00;

  // Shifts and sector handed from front to back
  typedef struct packed {
    logic [4:0] ma;  // shift of s on even chips
    logic [4:0] mb;  // shift of s on odd chips
    logic [2:0] mz;  // shift of z
    logic [1:0] n2;  // sector, shift of c
  } sss_cmd_t;

  // Quotient by 30 for values up to 239, by constant compares
  function automatic logic [2:0] div30_f(input logic [7:0] v);
    logic [2:0] q;
    q = '0;
    for (int k = 1; k < 8; k++) begin
      if (v >= 8'(k * 30)) q = 3'(k);
    end
    return q;
  endfunction

  // Quotient by 31 for values up to 247, by constant compares
  function automatic logic [2:0] div31_f(input logic [7:0] v);
    logic [2:0] q;
    q = '0;
    for (int k = 1; k < 8; k++) begin
      if (v >= 8'(k * 31)) q = 3'(k);
    end
    return q;
  endfunction

  // Triangular number k(k+1)/2 for k up to 7
  function automatic logic [4:0] tri_f(input logic [2:0] k);
    logic [4:0] t;
    case (k)
      3'd0:    t = 5'd0;
      3'd1:    t = 5'd1;
      3'd2:    t = 5'd3;
      3'd3:    t = 5'd6;
      3'd4:    t = 5'd10;
      3'd5:    t = 5'd15;
      3'd6:    t = 5'd21;
      3'd7:    t = 5'd28;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // Reduce mod 31 a value known to be below 62
  function automatic logic [4:0] mod31_f(input logic [5:0] v);
    logic [5:0] r;
    r = (v >= 6'd31) ? (v - 6'd31) : v;
    return r[4:0];
  endfunction

endpackage

FILE: rtl/lte_sss_sequence_generator.sv
// LTE SSS generator top: front pipeline, command queue, chip sequencer.
// An input word passes the front pipeline, command queue and output register.
// One chip word per cycle while pops and commands allow; the back-end sequencer
// takes one cell_id word per 62-chip sequence (63 with the DC sample).
// Reset: dc_en_q clears to 0, all pipeline stages and queues empty.
// Depends on sss_pkg, sss_front, sss_cmd_fifo, sss_back.
module lte_sss_sequence_generator #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [8:0]        cell_id_i,
  input  logic              second_half_i,
  output logic              empty,
  input  logic              pop,
  output logic signed [1:0] chip_o,
  output logic [5:0]        position_o,
  output logic              last_o
);

  logic dc_en_q;

  logic              f_valid, q_full, q_empty, q_pop;
  sss_pkg::sss_cmd_t f_cmd, q_cmd;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dc_en_q <= 1'b0;
    else if (cfg_we_i) dc_en_q <= cfg_wdata_i;
  end

  sss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .cell_id_i     (cell_id_i),
    .second_half_i (second_half_i),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (!q_full),
    .cmd_o         (f_cmd)
  );

  sss_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .empty_o (q_empty)
  );

  sss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dc_en_i     (dc_en_q),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty       (empty),
    .pop         (pop),
    .chip_o      (chip_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  // last word sits at the end of a 62 or 63 word sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |->
      ((dc_en_q && position_o == sss_pkg::PosLastDc) ||
       (!dc_en_q && position_o == sss_pkg::PosLastNoDc)))
    else $error("last flag at wrong position");

  // zero chip only in the DC slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && chip_o == sss_pkg::ChipZero) |->
      (dc_en_q && position_o == sss_pkg::PosDc))
    else $error("zero chip outside DC slot");

  // positions advance by one within a sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) ##1 !empty |->
      (position_o == $past(position_o) + 6'd1))
    else $error("position skipped");

  // back end never pulls from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("command pop while queue empty");

endmodule

FILE: rtl/sss_front.sv
// Front end: accepts cell_id / subframe words and derives sector and shifts.
// Four-stage pipeline; depends on sss_pkg.
module sss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [8:0]          cell_id_i,
  input  logic                second_half_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output sss_pkg::sss_cmd_t   cmd_o
);

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage payloads
  logic [8:0] s1_cid_q;
  logic       s1_half_q, s2_half_q, s3_half_q, s4_half_q;
  logic [7:0] s1_n1_q, s2_n1_q, s3_n1_q;
  logic [1:0] s2_n2_q, s3_n2_q, s4_n2_q;
  logic [2:0] s2_qp_q, s3_q_q;
  logic [7:0] s4_mp_q;

  logic [18:0] n1_prod;
  logic [8:0]  n2_full;
  logic [7:0]  q_sum;
  logic [2:0]  qm;
  logic [7:0]  m0_w;
  logic [4:0]  m0, m1;

  // ready ripples back from the queue
  assign rdy4 = !v4_q || cmd_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign full = !rdy1;

  // group number by reciprocal multiply
  assign n1_prod = 19'(cell_id_i) * 19'(sss_pkg::Div3Mul);
  // sector from remainder
  assign n2_full = s1_cid_q - (9'(s1_n1_q) * 9'd3);
  // q = (N1 + q'(q'+1)/2) / 30
  assign q_sum   = s2_n1_q + 8'(sss_pkg::tri_f(s2_qp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= push;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_cid_q  <= cell_id_i;
      s1_half_q <= second_half_i;
      s1_n1_q   <= n1_prod[sss_pkg::Div3Shift +: 8];
    end
    if (rdy2) begin
      s2_half_q <= s1_half_q;
      s2_n1_q   <= s1_n1_q;
      s2_n2_q   <= n2_full[1:0];
      s2_qp_q   <= sss_pkg::div30_f(s1_n1_q);
    end
    if (rdy3) begin
      s3_half_q <= s2_half_q;
      s3_n1_q   <= s2_n1_q;
      s3_n2_q   <= s2_n2_q;
      s3_q_q    <= sss_pkg::div30_f(q_sum);
    end
    if (rdy4) begin
      s4_half_q <= s3_half_q;
      s4_n2_q   <= s3_n2_q;
      s4_mp_q   <= s3_n1_q + 8'(sss_pkg::tri_f(s3_q_q));
    end
  end

  // m0 = m' mod 31, m1 = (m0 + m'/31 + 1) mod 31
  assign qm   = sss_pkg::div31_f(s4_mp_q);
  assign m0_w = s4_mp_q - 8'(8'(qm) * 8'd31);
  assign m0   = m0_w[4:0];
  assign m1   = sss_pkg::mod31_f(6'(m0) + 6'(qm) + 6'd1);

  // subframe select swaps the shifts
  always_comb begin
    cmd_o.ma = s4_half_q ? m1 : m0;
    cmd_o.mb = s4_half_q ? m0 : m1;
    cmd_o.mz = cmd_o.ma[2:0];
    cmd_o.n2 = s4_n2_q;
  end

  assign cmd_valid_o = v4_q;

endmodule

FILE: rtl/sss_cmd_fifo.sv
// Small command queue between front and back ends.
// Holds sss_pkg::sss_cmd_t words; depends on sss_pkg.
module sss_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sss_pkg::sss_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output sss_pkg::sss_cmd_t data_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sss_pkg::sss_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: rtl/sss_back.sv
// Back end: walks the positions of one sequence and forms each chip.
// Output register feeds the result queue ports; depends on sss_pkg.
module sss_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    dc_en_i,
  input  logic                    cmd_valid_i,
  input  sss_pkg::sss_cmd_t       cmd_i,
  output logic                    cmd_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [1:0]       chip_o,
  output logic [5:0]              position_o,
  output logic                    last_o
);

  logic [5:0] pos_q;
  logic       out_valid_q;
  logic signed [1:0] chip_q;
  logic [5:0] out_pos_q;
  logic       out_last_q;

  logic       load, is_last, is_dc, odd, bit_v;
  logic [5:0] src;
  logic [4:0] n, ms, is_s, is_c, is_z;
  logic signed [1:0] chip_d;

  // output register refills whenever it is free or being taken and a command waits
  assign load    = cmd_valid_i && (!out_valid_q || pop);
  assign is_last = dc_en_i ? (pos_q == sss_pkg::PosLastDc) : (pos_q == sss_pkg::PosLastNoDc);
  assign is_dc   = dc_en_i && (pos_q == sss_pkg::PosDc);
  assign cmd_pop_o = load && is_last;

  // source chip index skips the DC slot
  assign src = (dc_en_i && (pos_q > sss_pkg::PosDc)) ? (pos_q - 6'd1) : pos_q;
  assign n   = src[5:1];
  assign odd = src[0];
  assign ms  = odd ? cmd_i.mb : cmd_i.ma;

  // cyclic indices into s, c, z
  assign is_s = sss_pkg::mod31_f(6'(n) + 6'(ms));
  assign is_c = sss_pkg::mod31_f(6'(n) + 6'(cmd_i.n2) + (odd ? 6'd3 : 6'd0));
  assign is_z = sss_pkg::mod31_f(6'(n) + 6'(cmd_i.mz));
  assign bit_v = sss_pkg::SeqS[is_s] ^ sss_pkg::SeqC[is_c] ^ (odd & sss_pkg::SeqZ[is_z]);

  always_comb begin
    if (is_dc) chip_d = sss_pkg::ChipZero;
    else if (bit_v) chip_d = sss_pkg::ChipNeg;
    else chip_d = sss_pkg::ChipPos;
  end

  // position counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) pos_q <= is_last ? '0 : pos_q + 6'd1;
      if (load) out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      chip_q     <= chip_d;
      out_pos_q  <= pos_q;
      out_last_q <= is_last;
    end
  end

  assign empty      = !out_valid_q;
  assign chip_o     = chip_q;
  assign position_o = out_pos_q;
  assign last_o     = out_last_q;

endmodule
